FILE: hw/rtl/atpsc_pkg.sv
// ----------------------------------------------------------------------------
// atpsc_pkg
// Shared types and constants for the two-phase signal controller.
// ----------------------------------------------------------------------------
`default_nettype none

package atpsc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int THR_W      = 9;
    localparam int GREEN_W    = 16;
    localparam int ENA_W      = 4;
    localparam int GT_W       = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_NS_THRESHOLD    = 3'd0;
    localparam t_cfg_idx REG_WE_THRESHOLD    = 3'd1;
    localparam t_cfg_idx REG_MIN_GREEN       = 3'd2;
    localparam t_cfg_idx REG_MAX_GREEN       = 3'd3;
    localparam t_cfg_idx REG_FIXED_INTERVAL  = 3'd4;
    localparam t_cfg_idx REG_APPROACH_ENABLE = 3'd5;

    localparam logic [GREEN_W-1:0] MIN_GREEN_RST      = 16'd300;
    localparam logic [GREEN_W-1:0] MAX_GREEN_RST      = 16'd1200;
    localparam logic [GREEN_W-1:0] FIXED_INTERVAL_RST = 16'd900;
    localparam logic [ENA_W-1:0]   APPROACH_ENA_RST   = 4'hF;

    localparam int ENA_W_BIT = 0;
    localparam int ENA_E_BIT = 1;
    localparam int ENA_N_BIT = 2;
    localparam int ENA_S_BIT = 3;

    localparam logic PHASE_NS = 1'b0;
    localparam logic PHASE_WE = 1'b1;

    typedef struct packed {
        logic [THR_W-1:0]   ns_threshold;
        logic [THR_W-1:0]   we_threshold;
        logic [GREEN_W-1:0] min_green;
        logic [GREEN_W-1:0] max_green;
        logic [GREEN_W-1:0] fixed_interval;
        logic [ENA_W-1:0]   approach_enable;
    } t_cfg;

    typedef struct packed {
        logic fixed_mode;
        logic we_hi;
        logic ns_hi;
    } t_flags;

endpackage

`default_nettype wire

FILE: hw/rtl/atpsc_if.sv
// ----------------------------------------------------------------------------
// atpsc_if
// Valid/ready channels of the signal controller: counts, results, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface atpsc_in_if #(
    parameter int COUNT_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] west_count;
    logic [COUNT_BITS-1:0] east_count;
    logic [COUNT_BITS-1:0] north_count;
    logic [COUNT_BITS-1:0] south_count;

    modport source (
        output valid, west_count, east_count, north_count, south_count,
        input  ready
    );
    modport sink (
        input  valid, west_count, east_count, north_count, south_count,
        output ready
    );
endinterface

interface atpsc_out_if;
    logic        valid;
    logic        ready;
    logic        phase;
    logic        changed;
    logic [15:0] green_time;

    modport source (
        output valid, phase, changed, green_time,
        input  ready
    );
    modport sink (
        input  valid, phase, changed, green_time,
        output ready
    );
endinterface

interface atpsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/atpsc_cfg.sv
// ----------------------------------------------------------------------------
// atpsc_cfg
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module atpsc_cfg
    import atpsc_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_wr_valid,
    input  wire  [CFG_IDX_W-1:0]  i_wr_index,
    input  wire  [CFG_DATA_W-1:0] i_wr_data,
    output logic                  o_wr_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_valid) begin
            unique case (t_cfg_idx'(i_wr_index))
                REG_NS_THRESHOLD:    n_cfg.ns_threshold    = i_wr_data[THR_W-1:0];
                REG_WE_THRESHOLD:    n_cfg.we_threshold    = i_wr_data[THR_W-1:0];
                REG_MIN_GREEN:       n_cfg.min_green       = i_wr_data[GREEN_W-1:0];
                REG_MAX_GREEN:       n_cfg.max_green       = i_wr_data[GREEN_W-1:0];
                REG_FIXED_INTERVAL:  n_cfg.fixed_interval  = i_wr_data[GREEN_W-1:0];
                REG_APPROACH_ENABLE: n_cfg.approach_enable = i_wr_data[ENA_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ns_threshold    <= '0;
            r_cfg.we_threshold    <= '0;
            r_cfg.min_green       <= MIN_GREEN_RST;
            r_cfg.max_green       <= MAX_GREEN_RST;
            r_cfg.fixed_interval  <= FIXED_INTERVAL_RST;
            r_cfg.approach_enable <= APPROACH_ENA_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/atpsc_intake.sv
// ----------------------------------------------------------------------------
// atpsc_intake
// Input register for the approach counts; axis sums and congestion flags.
// ----------------------------------------------------------------------------
`default_nettype none

module atpsc_intake
    import atpsc_pkg::*;
#(
    parameter int COUNT_BITS = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire  [COUNT_BITS-1:0] i_west_count,
    input  wire  [COUNT_BITS-1:0] i_east_count,
    input  wire  [COUNT_BITS-1:0] i_north_count,
    input  wire  [COUNT_BITS-1:0] i_south_count,
    input  wire  t_cfg            i_cfg,
    input  wire                   i_adv,
    output logic                  o_valid,
    output t_flags                o_flags
);

    localparam int SUM_W = (COUNT_BITS + 1 > THR_W) ? COUNT_BITS + 1 : THR_W;

    logic                  r_valid;
    logic [COUNT_BITS-1:0] r_west;
    logic [COUNT_BITS-1:0] r_east;
    logic [COUNT_BITS-1:0] r_north;
    logic [COUNT_BITS-1:0] r_south;

    logic [COUNT_BITS-1:0] w_west;
    logic [COUNT_BITS-1:0] w_east;
    logic [COUNT_BITS-1:0] w_north;
    logic [COUNT_BITS-1:0] w_south;
    logic [SUM_W-1:0]      w_we_sum;
    logic [SUM_W-1:0]      w_ns_sum;

    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_west  <= i_west_count;
            r_east  <= i_east_count;
            r_north <= i_north_count;
            r_south <= i_south_count;
        end
    end

    always_comb begin
        w_west  = i_cfg.approach_enable[ENA_W_BIT] ? r_west  : '0;
        w_east  = i_cfg.approach_enable[ENA_E_BIT] ? r_east  : '0;
        w_north = i_cfg.approach_enable[ENA_N_BIT] ? r_north : '0;
        w_south = i_cfg.approach_enable[ENA_S_BIT] ? r_south : '0;
        w_we_sum = SUM_W'(w_west) + SUM_W'(w_east);
        w_ns_sum = SUM_W'(w_north) + SUM_W'(w_south);
        o_flags.fixed_mode = (i_cfg.ns_threshold == '0) && (i_cfg.we_threshold == '0);
        o_flags.we_hi      = w_we_sum >= SUM_W'(i_cfg.we_threshold);
        o_flags.ns_hi      = w_ns_sum >= SUM_W'(i_cfg.ns_threshold);
    end

endmodule

`default_nettype wire

FILE: hw/rtl/atpsc_core.sv
// ----------------------------------------------------------------------------
// atpsc_core
// Phase decision, green timers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module atpsc_core
    import atpsc_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    input  wire  t_flags       i_flags,
    input  wire  t_cfg         i_cfg,
    output logic               o_adv,
    output logic               o_valid,
    input  wire                i_ready,
    output logic               o_phase,
    output logic               o_changed,
    output logic [GT_W-1:0]    o_green_time
);

    localparam int CW = (TIMER_BITS > GREEN_W) ? TIMER_BITS : GREEN_W;
    localparam logic [TIMER_BITS-1:0] TMR_MAX = {TIMER_BITS{1'b1}};
    localparam logic [CW-1:0] GT_MAX = CW'({GT_W{1'b1}});

    logic                  r_phase;
    logic [TIMER_BITS-1:0] r_ns_timer;
    logic [TIMER_BITS-1:0] r_we_timer;
    logic                  r_out_valid;
    logic                  r_out_phase;
    logic                  r_out_changed;
    logic [GT_W-1:0]       r_out_gt;

    logic                  n_phase;
    logic [TIMER_BITS-1:0] n_ns_timer;
    logic [TIMER_BITS-1:0] n_we_timer;
    logic [GT_W-1:0]       n_gt;

    logic [CW-1:0]         w_ns;
    logic [CW-1:0]         w_we;
    logic [CW-1:0]         w_gt;
    logic                  w_flip;

    assign o_adv        = i_valid && (!r_out_valid || i_ready);
    assign o_valid      = r_out_valid;
    assign o_phase      = r_out_phase;
    assign o_changed    = r_out_changed;
    assign o_green_time = r_out_gt;

    always_comb begin
        w_ns = CW'(r_ns_timer);
        w_we = CW'(r_we_timer);
        priority if (i_flags.fixed_mode) begin
            w_flip = (w_we > CW'(i_cfg.fixed_interval)) || (w_ns > CW'(i_cfg.fixed_interval));
        end else if (i_flags.we_hi == i_flags.ns_hi) begin
            w_flip = (w_we > CW'(i_cfg.max_green)) || (w_ns > CW'(i_cfg.max_green));
        end else if (i_flags.we_hi) begin
            w_flip = (w_ns > CW'(i_cfg.min_green)) || (w_we > CW'(i_cfg.max_green));
        end else begin
            w_flip = (w_we > CW'(i_cfg.min_green)) || (w_ns > CW'(i_cfg.max_green));
        end

        n_phase = r_phase ^ w_flip;
        if (n_phase == PHASE_NS) begin
            n_ns_timer = (r_ns_timer == TMR_MAX) ? r_ns_timer : r_ns_timer + 1'b1;
            n_we_timer = '0;
            w_gt       = CW'(n_ns_timer);
        end else begin
            n_we_timer = (r_we_timer == TMR_MAX) ? r_we_timer : r_we_timer + 1'b1;
            n_ns_timer = '0;
            w_gt       = CW'(n_we_timer);
        end
        n_gt = (w_gt > GT_MAX) ? {GT_W{1'b1}} : w_gt[GT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PHASE_NS;
            r_ns_timer  <= '0;
            r_we_timer  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_phase    <= n_phase;
                r_ns_timer <= n_ns_timer;
                r_we_timer <= n_we_timer;
            end
            if (o_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_out_phase   <= n_phase;
            r_out_changed <= w_flip;
            r_out_gt      <= n_gt;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/adaptive_two_phase_signal_controller_top.sv
// Path: an input transfer is captured in the input register and its result
//   in the result register, which holds it until the output is ready.
// Throughput: one item per cycle; a stalled result holds both registers, so
//   one more item is taken into the input register and then input stalls.
// Reset: synchronous, active low; north-south green, both timers and all
//   valid flags cleared, configuration registers at their defaults.
// ----------------------------------------------------------------------------
// adaptive_two_phase_signal_controller_top
// Two-phase actuated intersection controller, one tick per input transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_two_phase_signal_controller_top
    import atpsc_pkg::*;
#(
    parameter int TIMER_BITS = 16,
    parameter int COUNT_BITS = 8
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    atpsc_in_if.sink       i_in,
    atpsc_out_if.source    o_out,
    atpsc_cfg_if.sink      i_cfg
);

    t_cfg   w_cfg;
    t_flags w_flags;
    logic   w_adv;
    logic   w_stage_valid;

    atpsc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_wr_ready (i_cfg.ready),
        .o_cfg      (w_cfg)
    );

    atpsc_intake #(
        .COUNT_BITS (COUNT_BITS)
    ) u_intake (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_west_count  (i_in.west_count),
        .i_east_count  (i_in.east_count),
        .i_north_count (i_in.north_count),
        .i_south_count (i_in.south_count),
        .i_cfg         (w_cfg),
        .i_adv         (w_adv),
        .o_valid       (w_stage_valid),
        .o_flags       (w_flags)
    );

    atpsc_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_stage_valid),
        .i_flags      (w_flags),
        .i_cfg        (w_cfg),
        .o_adv        (w_adv),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_phase      (o_out.phase),
        .o_changed    (o_out.changed),
        .o_green_time (o_out.green_time)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/atpsc_checker.sv
// ----------------------------------------------------------------------------
// atpsc_checker
// Port-level checks on the result stream of the signal controller.
// ----------------------------------------------------------------------------
`default_nettype none

module atpsc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire        i_out_phase,
    input wire        i_out_changed,
    input wire [15:0] i_out_green_time
);

    logic        r_last_phase;
    logic [15:0] r_last_gt;
    logic        w_xfer;

    assign w_xfer = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase <= 1'b0;
            r_last_gt    <= '0;
        end else if (w_xfer) begin
            r_last_phase <= i_out_phase;
            r_last_gt    <= i_out_green_time;
        end
    end

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_phase_follows_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer |-> (i_out_changed == (i_out_phase != r_last_phase)))
        else $error("phase and change flag disagree");

    a_new_green_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && i_out_changed |-> i_out_green_time == 16'd1)
        else $error("green time not restarted on change");

    a_green_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && !i_out_changed |->
            (i_out_green_time == r_last_gt + 16'd1) || (i_out_green_time == r_last_gt))
        else $error("green time did not advance");

endmodule

bind adaptive_two_phase_signal_controller_top atpsc_checker u_atpsc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_phase      (o_out.phase),
    .i_out_changed    (o_out.changed),
    .i_out_green_time (o_out.green_time)
);

`default_nettype wire
